/* rtl/core/deq_pkg.sv */
// shared types, widths and codes of the deadline event queue
`default_nettype none

package deq_pkg;

  // default sizing of the queue
  localparam int DEPTH_DEF     = 16;
  localparam int ID_BITS_DEF   = 8;
  localparam int TIME_BITS_DEF = 32;

  // most expired events reported by one tick
  localparam int RESULT_LIMIT = 16;

  // fixed field widths of the channels
  localparam int ACTION_W   = 3;
  localparam int EVENT_ID_W = 8;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_AT     = 3'd0,
    ACT_ADD_AFTER  = 3'd1,
    ACT_CANCEL     = 3'd2,
    ACT_CANCEL_ALL = 3'd3,
    ACT_TICK       = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_DUP       = 2'd3
  } status_t;

  // operation on the sorted table
  typedef enum logic [1:0] {
    TBL_NONE,
    TBL_INSERT,
    TBL_REMOVE,
    TBL_CLEAR
  } tbl_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_SCAN,
    S_APPLY,
    S_REPLY,
    S_TICK
  } state_t;

endpackage : deq_pkg

`default_nettype wire

/* rtl/core/deq_ifs.sv */
// request and result channel interfaces of the deadline event queue
`default_nettype none

interface deq_in_if
  import deq_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [EVENT_ID_W-1:0] event_id;
  logic [TIME_W-1:0]     when;
  logic [TIME_W-1:0]     now;

  modport source (output valid, action, event_id, when, now, input ready);
  modport sink   (input valid, action, event_id, when, now, output ready);
endinterface : deq_in_if

interface deq_out_if
  import deq_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [EVENT_ID_W-1:0] fired_id;
  logic                  fired;
  logic [STATUS_W-1:0]   status;
  logic                  last;

  modport source (output valid, fired_id, fired, status, last, input ready);
  modport sink   (input valid, fired_id, fired, status, last, output ready);
endinterface : deq_out_if

`default_nettype wire

/* rtl/core/deadline_event_queue.sv */
// top level of the deadline event queue: sequencer, table and result register
`default_nettype none

// Timer event queue holding up to DEPTH pending (id, deadline) entries sorted by
// deadline, equal deadlines in arrival order. A request is taken only while the
// block is idle; it is then worked through by a small sequencer around one shared
// add/compare unit that reads the table one slot per cycle. Add at a deadline
// scans one slot per pending entry, stopping early on a duplicate id; add after a
// delay first forms the saturating sum, and cancel by id scans the same way;
// cancel all and unknown actions skip the scan. A tick removes expired events
// from the head, up to RESULT_LIMIT events per tick; expired events past
// that limit stay queued. Each request gives one result beat, a tick one beat per
// expired event with last on the final one. Results sit in an output register, so
// the table work does not wait on the consumer until a second beat is due.

module deadline_event_queue
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  localparam int IDW = (ID_BITS < EVENT_ID_W) ? ID_BITS : EVENT_ID_W;
  localparam int TW  = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int NW  = $clog2(RESULT_LIMIT + 1);

  state_t state_r, state_nxt;

  logic [ACTION_W-1:0] act_r;
  logic [IDW-1:0]      id_r;
  logic [TW-1:0]       key_r;
  logic [TW-1:0]       addend_r;
  logic [CW-1:0]       idx_r;
  logic [AW-1:0]       pos_r;
  logic                found_r;
  logic                pos_found_r;
  logic [STATUS_W-1:0] status_r;
  logic [NW-1:0]       n_r;
  logic                hold_valid_r;
  logic [IDW-1:0]      hold_id_r;

  logic                  out_valid_r;
  logic [EVENT_ID_W-1:0] out_fired_id_r;
  logic                  out_fired_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic                  out_last_r;

  tbl_op_t        tbl_op;
  logic [AW-1:0]  tbl_pos;
  logic [IDW-1:0] rd_id;
  logic [TW-1:0]  rd_deadline;
  logic [CW-1:0]  tbl_count;

  logic          later;
  logic          id_eq;
  logic [TW-1:0] sum_sat;

  logic                  in_take;
  logic                  out_free;
  logic                  is_add;
  logic                  scan_live;
  logic                  scan_hit;
  logic                  scan_done;
  logic                  tick_hit;
  logic                  tick_take;
  logic                  out_load;
  logic [EVENT_ID_W-1:0] out_fired_id_nxt;
  logic                  out_fired_nxt;
  logic [STATUS_W-1:0]   out_status_nxt;
  logic                  out_last_nxt;
  logic [STATUS_W-1:0]   apply_status;

  deq_table #(
    .DEPTH (DEPTH),
    .IDW   (IDW),
    .TW    (TW)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (tbl_op),
    .pos         (tbl_pos),
    .wr_id       (id_r),
    .wr_deadline (key_r),
    .rd_idx      (idx_r[AW-1:0]),
    .rd_id       (rd_id),
    .rd_deadline (rd_deadline),
    .count       (tbl_count)
  );

  deq_unit #(
    .IDW (IDW),
    .TW  (TW)
  ) u_unit (
    .entry_deadline (rd_deadline),
    .entry_id       (rd_id),
    .key            (key_r),
    .key_id         (id_r),
    .addend         (addend_r),
    .later          (later),
    .id_eq          (id_eq),
    .sum_sat        (sum_sat)
  );

  // handshake and decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign is_add      = (act_r == ACT_ADD_AT) || (act_r == ACT_ADD_AFTER);
  assign scan_live   = idx_r < tbl_count;
  assign scan_hit    = scan_live && id_eq;
  assign scan_done   = !scan_live || scan_hit;
  assign tick_hit    = (tbl_count != '0) && !later && (n_r < NW'(RESULT_LIMIT));
  assign tick_take   = (state_r == S_TICK) && tick_hit && (!hold_valid_r || out_free);

  // status once the scan is over
  always_comb begin
    apply_status = STATUS_OK;
    if (is_add) begin
      if (found_r) begin
        apply_status = STATUS_DUP;
      end else if (tbl_count == CW'(DEPTH)) begin
        apply_status = STATUS_FULL;
      end
    end else if (act_r == ACT_CANCEL && !found_r) begin
      apply_status = STATUS_NOT_FOUND;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          unique case (in_ch.action)
            ACT_ADD_AFTER:          state_nxt = S_SUM;
            ACT_ADD_AT, ACT_CANCEL: state_nxt = S_SCAN;
            ACT_TICK:               state_nxt = S_TICK;
            default:                state_nxt = S_APPLY;
          endcase
        end
      end
      S_SUM: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: state_nxt = S_REPLY;
      S_REPLY: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (!tick_hit && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: table operation and result beat
  always_comb begin
    tbl_op           = TBL_NONE;
    tbl_pos          = '0;
    out_load         = 1'b0;
    out_fired_id_nxt = '0;
    out_fired_nxt    = 1'b0;
    out_status_nxt   = STATUS_OK;
    out_last_nxt     = 1'b1;
    unique case (state_r)
      S_APPLY: begin
        if (is_add && apply_status == STATUS_OK) begin
          tbl_op  = TBL_INSERT;
          tbl_pos = pos_found_r ? pos_r : tbl_count[AW-1:0];
        end else if (act_r == ACT_CANCEL && found_r) begin
          tbl_op  = TBL_REMOVE;
          tbl_pos = pos_r;
        end else if (act_r == ACT_CANCEL_ALL) begin
          tbl_op = TBL_CLEAR;
        end
      end
      S_REPLY: begin
        out_load       = out_free;
        out_status_nxt = status_r;
      end
      S_TICK: begin
        if (tick_take) begin
          tbl_op = TBL_REMOVE;
          // the held event is followed by another, so it is not last
          out_load         = hold_valid_r;
          out_fired_id_nxt = EVENT_ID_W'(hold_id_r);
          out_fired_nxt    = 1'b1;
          out_last_nxt     = 1'b0;
        end else if (!tick_hit && out_free) begin
          out_load         = 1'b1;
          out_fired_id_nxt = hold_valid_r ? EVENT_ID_W'(hold_id_r) : '0;
          out_fired_nxt    = hold_valid_r;
        end
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request fields and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      found_r      <= 1'b0;
      pos_found_r  <= 1'b0;
      n_r          <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        act_r        <= in_ch.action;
        id_r         <= in_ch.event_id[IDW-1:0];
        key_r        <= (in_ch.action == ACT_ADD_AT) ? in_ch.when[TW-1:0] : in_ch.now[TW-1:0];
        addend_r     <= in_ch.when[TW-1:0];
        idx_r        <= '0;
        found_r      <= 1'b0;
        pos_found_r  <= 1'b0;
        n_r          <= '0;
        hold_valid_r <= 1'b0;
      end
      if (state_r == S_SUM) begin
        key_r <= sum_sat;
      end
      // one slot per cycle through the shared compare
      if (state_r == S_SCAN && scan_live) begin
        if (id_eq) begin
          found_r <= 1'b1;
          pos_r   <= idx_r[AW-1:0];
        end else begin
          if (is_add && later && !pos_found_r) begin
            pos_found_r <= 1'b1;
            pos_r       <= idx_r[AW-1:0];
          end
          idx_r <= CW'(idx_r + 1'b1);
        end
      end
      if (state_r == S_APPLY) begin
        status_r <= apply_status;
      end
      // head leaves the table and waits until its last flag is known
      if (tick_take) begin
        hold_valid_r <= 1'b1;
        hold_id_r    <= rd_id;
        n_r          <= NW'(n_r + 1'b1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fired_id_r <= out_fired_id_nxt;
      out_fired_r    <= out_fired_nxt;
      out_status_r   <= out_status_nxt;
      out_last_r     <= out_last_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.fired_id = out_fired_id_r;
  assign out_ch.fired    = out_fired_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

  // checks on the sequencer and table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_count <= CW'(DEPTH))
    else $error("pending count above depth");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_op == TBL_INSERT |-> tbl_count < CW'(DEPTH))
    else $error("insert into a full table");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_op == TBL_CLEAR |=> tbl_count == '0)
    else $error("cancel all left entries behind");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result beat overwritten while stalled");

  a_unfired_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_fired_r |-> out_last_r && out_fired_id_r == '0)
    else $error("non-event result not marked last");

endmodule : deadline_event_queue

`default_nettype wire

/* rtl/core/deq_table.sv */
// deadline-sorted entry table with insert and remove done by shifting entries
`default_nettype none

module deq_table
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDW   = ID_BITS_DEF,
  parameter int TW    = TIME_BITS_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tbl_op_t       op,
  input  wire logic [AW-1:0] pos,
  input  wire logic [IDW-1:0] wr_id,
  input  wire logic [TW-1:0] wr_deadline,
  input  wire logic [AW-1:0] rd_idx,
  output logic [IDW-1:0]     rd_id,
  output logic [TW-1:0]      rd_deadline,
  output logic [CW-1:0]      count
);

  logic [TW-1:0]  dl_r [DEPTH];
  logic [IDW-1:0] id_r [DEPTH];
  logic [CW-1:0]  count_r;

  // entry shifts: open a slot at pos, or close the slot at pos
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      unique case (op)
        TBL_INSERT: begin
          if (AW'(i) == pos) begin
            dl_r[i] <= wr_deadline;
            id_r[i] <= wr_id;
          end else if (i > 0 && AW'(i) > pos && CW'(i) <= count_r) begin
            dl_r[i] <= dl_r[(i > 0) ? i - 1 : 0];
            id_r[i] <= id_r[(i > 0) ? i - 1 : 0];
          end
        end
        TBL_REMOVE: begin
          if (i < DEPTH - 1 && AW'(i) >= pos && CW'(i + 1) < count_r) begin
            dl_r[i] <= dl_r[(i < DEPTH - 1) ? i + 1 : i];
            id_r[i] <= id_r[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // fill count; slots below it are the pending entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      unique case (op)
        TBL_INSERT: count_r <= CW'(count_r + 1'b1);
        TBL_REMOVE: count_r <= CW'(count_r - 1'b1);
        TBL_CLEAR:  count_r <= '0;
        default:    count_r <= count_r;
      endcase
    end
  end

  // single scan read port
  assign rd_deadline = dl_r[rd_idx];
  assign rd_id       = id_r[rd_idx];
  assign count       = count_r;

endmodule : deq_table

`default_nettype wire

/* rtl/core/deq_unit.sv */
// shared arithmetic unit: saturating add, deadline compare, id match
`default_nettype none

module deq_unit
  import deq_pkg::*;
#(
  parameter int IDW = ID_BITS_DEF,
  parameter int TW  = TIME_BITS_DEF
) (
  input  wire logic [TW-1:0]  entry_deadline,
  input  wire logic [IDW-1:0] entry_id,
  input  wire logic [TW-1:0]  key,
  input  wire logic [IDW-1:0] key_id,
  input  wire logic [TW-1:0]  addend,
  output logic                later,
  output logic                id_eq,
  output logic [TW-1:0]       sum_sat
);

  logic [TW:0] sum_full;

  // key plus addend, clamped to the largest time on carry out
  assign sum_full = {1'b0, key} + {1'b0, addend};
  assign sum_sat  = sum_full[TW] ? {TW{1'b1}} : sum_full[TW-1:0];

  // entry deadline strictly after the key
  assign later = entry_deadline > key;
  assign id_eq = entry_id == key_id;

endmodule : deq_unit

`default_nettype wire
